// ===== sv/mks_pkg.sv =====
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types and constants for the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int PIN_W      = 8;   // row and column pin vector width
    localparam int CODE_W     = 6;
    localparam int ROW_IDX_W  = 3;
    localparam int COL_IDX_W  = 4;
    localparam int COUNT_W    = 4;
    localparam int WAIT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEFAULT_MAX_ROWS = 8;
    localparam int DEFAULT_MAX_COLS = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd2;

    localparam logic [COUNT_W-1:0] RESET_ROW_COUNT = 4'd4;
    localparam logic [COUNT_W-1:0] RESET_COL_COUNT = 4'd4;
    localparam logic [WAIT_W-1:0]  RESET_DEBOUNCE  = 16'd50;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_ROWS = 3'b100
    } phase_t;

    typedef struct packed {
        logic [COUNT_W-1:0] row_count;
        logic [COUNT_W-1:0] col_count;
        logic [WAIT_W-1:0]  debounce_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t               phase;
        logic [ROW_IDX_W-1:0] scan_row;
        logic [COL_IDX_W-1:0] scan_col;
        logic [WAIT_W-1:0]    wait_count;
    } state_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              key_pressed;
        logic              scan_done;
        logic [PIN_W-1:0]  row_drive;
    } result_t;

endpackage

// ===== sv/mks_step.sv =====
// ----------------------------------------------------------------------------
// mks_step
// Next-state and result logic for one scan tick.
// ----------------------------------------------------------------------------
module mks_step #(
    parameter int MAX_ROWS = mks_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = mks_pkg::DEFAULT_MAX_COLS
) (
    input  mks_pkg::cfg_t                  cfg,
    input  mks_pkg::state_t                state_cur,
    input  logic [mks_pkg::PIN_W-1:0]      col_levels,
    output mks_pkg::state_t                state_nxt,
    output mks_pkg::result_t               result
);

    localparam int ROW_LIM_I = (MAX_ROWS < mks_pkg::PIN_W) ? MAX_ROWS : mks_pkg::PIN_W;
    localparam int COL_LIM_I = (MAX_COLS < mks_pkg::PIN_W) ? MAX_COLS : mks_pkg::PIN_W;
    localparam logic [mks_pkg::COUNT_W-1:0] ROW_LIM = mks_pkg::COUNT_W'(ROW_LIM_I);
    localparam logic [mks_pkg::COUNT_W-1:0] COL_LIM = mks_pkg::COUNT_W'(COL_LIM_I);

    logic [mks_pkg::COUNT_W-1:0]   rows;
    logic [mks_pkg::COUNT_W-1:0]   cols;
    logic [mks_pkg::PIN_W-1:0]     all_low;
    logic [mks_pkg::PIN_W-1:0]     cand;
    logic                          found;
    logic [mks_pkg::COL_IDX_W-1:0] found_col;
    logic                          col_low;
    logic [mks_pkg::PIN_W-1:0]     code_sum;
    logic [mks_pkg::COUNT_W-1:0]   row_inc;

    // Clamp counts into 1..limit
    always_comb begin
        if (cfg.row_count == '0) begin
            rows = 4'd1;
        end else if (cfg.row_count > ROW_LIM) begin
            rows = ROW_LIM;
        end else begin
            rows = cfg.row_count;
        end
        if (cfg.col_count == '0) begin
            cols = 4'd1;
        end else if (cfg.col_count > COL_LIM) begin
            cols = COL_LIM;
        end else begin
            cols = cfg.col_count;
        end
    end

    // Used rows low, unused rows high; candidate columns for the search
    always_comb begin
        for (int i = 0; i < mks_pkg::PIN_W; i++) begin
            all_low[i] = (mks_pkg::COUNT_W'(i) >= rows);
            cand[i]    = !col_levels[i]
                         && (mks_pkg::COL_IDX_W'(i) >= state_cur.scan_col)
                         && (mks_pkg::COUNT_W'(i) < cols);
        end
    end

    // Lowest candidate column wins
    always_comb begin
        found     = 1'b0;
        found_col = '0;
        for (int i = mks_pkg::PIN_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found     = 1'b1;
                found_col = mks_pkg::COL_IDX_W'(i);
            end
        end
    end

    assign col_low  = (state_cur.scan_col < cols)
                      && ({1'b0, state_cur.scan_row} < rows)
                      && !col_levels[state_cur.scan_col[mks_pkg::ROW_IDX_W-1:0]];
    assign code_sum = 8'(state_cur.scan_row) * 8'(cols) + 8'(state_cur.scan_col);
    assign row_inc  = {1'b0, state_cur.scan_row} + 4'd1;

    always_comb begin
        state_nxt          = state_cur;
        result.row_drive   = all_low;
        result.scan_done   = 1'b0;
        result.key_pressed = 1'b0;
        result.key_code    = '0;

        unique case (state_cur.phase)
            mks_pkg::PH_WAIT: begin
                if (state_cur.wait_count > 16'd1) begin
                    state_nxt.wait_count = state_cur.wait_count - 16'd1;
                end else begin
                    state_nxt.wait_count = '0;
                    state_nxt.phase      = mks_pkg::PH_ROWS;
                    state_nxt.scan_row   = '0;
                    result.row_drive     = 8'hFE;
                end
            end
            mks_pkg::PH_ROWS: begin
                if (col_low) begin
                    result.scan_done   = 1'b1;
                    result.key_pressed = 1'b1;
                    result.key_code    = code_sum[mks_pkg::CODE_W-1:0];
                    state_nxt.phase    = mks_pkg::PH_IDLE;
                    state_nxt.scan_col = '0;
                end else if (row_inc < rows) begin
                    state_nxt.scan_row = row_inc[mks_pkg::ROW_IDX_W-1:0];
                    result.row_drive   = ~(8'h01 << row_inc[mks_pkg::ROW_IDX_W-1:0]);
                end else begin
                    // column exhausted: restore all used rows low, try next column
                    state_nxt.phase    = mks_pkg::PH_IDLE;
                    state_nxt.scan_row = '0;
                    state_nxt.scan_col = state_cur.scan_col + 4'd1;
                end
            end
            default: begin
                // idle, and any illegal phase code
                if (!found) begin
                    result.scan_done   = 1'b1;
                    state_nxt.phase    = mks_pkg::PH_IDLE;
                    state_nxt.scan_col = '0;
                end else begin
                    state_nxt.scan_col = found_col;
                    if (cfg.debounce_ticks == '0) begin
                        state_nxt.phase    = mks_pkg::PH_ROWS;
                        state_nxt.scan_row = '0;
                        result.row_drive   = 8'hFE;
                    end else begin
                        state_nxt.phase      = mks_pkg::PH_WAIT;
                        state_nxt.wait_count = cfg.debounce_ticks;
                    end
                end
            end
        endcase
    end

endmodule

// ===== sv/matrix_keypad_scanner.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Keypad matrix scanner with debounce, one column sample per scan tick.
// ----------------------------------------------------------------------------
// Each transaction on the s_ channel is one sampled column word; each brings
// exactly one m_ transaction carrying the row pattern to drive on the next
// tick plus scan status. The block takes one item per clock cycle unless
// the m_ side stalls: the tick logic sits between the scan state registers
// and a single output register, and s_tready stays high as long as that
// output register is empty or being drained. Configuration writes take
// effect on the clock edge at which cfg_wr_en is high.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner #(
    parameter int MAX_ROWS = mks_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = mks_pkg::DEFAULT_MAX_COLS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mks_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mks_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] col_levels
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] row_drive, [8] scan_done, [9] key_pressed, [15:10] key_code
    output logic [15:0]                      m_tdata
);

    mks_pkg::cfg_t    cfg_reg;
    mks_pkg::state_t  state_reg;
    mks_pkg::state_t  state_next;
    mks_pkg::result_t result_next;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    mks_step #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .col_levels(s_tdata),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_count      <= mks_pkg::RESET_ROW_COUNT;
            cfg_reg.col_count      <= mks_pkg::RESET_COL_COUNT;
            cfg_reg.debounce_ticks <= mks_pkg::RESET_DEBOUNCE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mks_pkg::REG_ROW_COUNT: cfg_reg.row_count      <= cfg_wdata[3:0];
                mks_pkg::REG_COL_COUNT: cfg_reg.col_count      <= cfg_wdata[3:0];
                mks_pkg::REG_DEBOUNCE:  cfg_reg.debounce_ticks <= cfg_wdata;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= mks_pkg::PH_IDLE;
            state_reg.scan_row   <= '0;
            state_reg.scan_col   <= '0;
            state_reg.wait_count <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {result_next.key_code, result_next.key_pressed,
                            result_next.scan_done, result_next.row_drive};
        end
    end

    a_pressed_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[8])
        else $error("key_pressed without scan_done");

    a_code_needs_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:10] != 6'd0) |-> m_tdata[9])
        else $error("nonzero key_code without key_pressed");

    a_done_rows_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> !m_tdata[0])
        else $error("finished scan does not drive row 0 low");

    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == mks_pkg::PH_WAIT |-> state_reg.wait_count != '0)
        else $error("debounce wait with zero count");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

endmodule
